// File: rtl/tfn_pkg.sv
// Package for the triangle face normal block: payload word types, width
// constants and the working word carried through the normalizing stages.
// No dependencies.
package tfn_pkg;

    localparam int COORD_WIDTH      = 16;
    localparam int NORMAL_FRAC_BITS = 14;
    localparam int OUT_WIDTH        = NORMAL_FRAC_BITS + 2;

    // Edge differences, products and the cross product.
    localparam int DIFF_WIDTH  = COORD_WIDTH + 1;
    localparam int PROD_WIDTH  = 2 * DIFF_WIDTH;
    localparam int CROSS_WIDTH = (PROD_WIDTH + 1 > 64) ? 64 : PROD_WIDTH + 1;
    localparam int SQ_WIDTH    = 2 * CROSS_WIDTH;
    localparam int LEN2_WIDTH  = SQ_WIDTH + 2;
    localparam int QUOT_WIDTH  = NORMAL_FRAC_BITS + 1;
    localparam int REM_WIDTH   = LEN2_WIDTH + 2 * NORMAL_FRAC_BITS + 2;

    // Pipeline depth of the cross product front end.
    localparam int FRONT_STAGES = 6;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] a_x;
        logic signed [COORD_WIDTH-1:0] a_y;
        logic signed [COORD_WIDTH-1:0] a_z;
        logic signed [COORD_WIDTH-1:0] b_x;
        logic signed [COORD_WIDTH-1:0] b_y;
        logic signed [COORD_WIDTH-1:0] b_z;
        logic signed [COORD_WIDTH-1:0] c_x;
        logic signed [COORD_WIDTH-1:0] c_y;
        logic signed [COORD_WIDTH-1:0] c_z;
    } t_tri_in;

    typedef struct packed {
        logic signed [OUT_WIDTH-1:0] normal_x;
        logic signed [OUT_WIDTH-1:0] normal_y;
        logic signed [OUT_WIDTH-1:0] normal_z;
        logic                        degenerate;
    } t_norm_out;

    // Per-lane state of the bit-by-bit quotient search.
    // rem  = m^2 * 2^(2F) - q^2 * len2, prod = q * len2.
    typedef struct packed {
        logic [2:0][REM_WIDTH-1:0]  rem;
        logic [2:0][REM_WIDTH-1:0]  prod;
        logic [2:0][QUOT_WIDTH-1:0] quot;
        logic [LEN2_WIDTH-1:0]      len2;
        logic [2:0]                 neg;
        logic                       degen;
    } t_norm_work;

endpackage

// File: rtl/tfn_cross.sv
// Front end of the face normal pipeline: edge vectors, cross product,
// magnitudes and squared length. Uses tfn_pkg.
module tfn_cross
    import tfn_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  t_tri_in    i_data,
    output logic       o_valid,
    input  logic       i_ready,
    output t_norm_work o_data
);

    logic [FRONT_STAGES-1:0] r_v;
    logic [FRONT_STAGES-1:0] adv;

    logic signed [DIFF_WIDTH-1:0]  r1_u [3];
    logic signed [DIFF_WIDTH-1:0]  r1_w [3];
    logic signed [PROD_WIDTH-1:0]  r2_p [6];
    logic signed [CROSS_WIDTH-1:0] r3_xp [3];
    logic [CROSS_WIDTH-1:0]        r4_m [3];
    logic [2:0]                    r4_neg;
    logic                          r4_zero;
    logic [SQ_WIDTH-1:0]           r5_sq [3];
    logic [2:0]                    r5_neg;
    logic                          r5_zero;
    t_norm_work                    r6_work;

    logic signed [PROD_WIDTH:0]    diffp [3];
    logic [LEN2_WIDTH-1:0]         len2_sum;

    // A stage takes a new word when it is empty or its word moves on.
    always_comb begin
        adv[FRONT_STAGES-1] = !r_v[FRONT_STAGES-1] || i_ready;
        for (int k = FRONT_STAGES - 2; k >= 0; k--) begin
            adv[k] = !r_v[k] || adv[k+1];
        end
    end

    assign o_ready = adv[0];
    assign o_valid = r_v[FRONT_STAGES-1];
    assign o_data  = r6_work;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (adv[0]) begin
                r_v[0] <= i_valid;
            end
            for (int k = 1; k < FRONT_STAGES; k++) begin
                if (adv[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    always_comb begin
        diffp[0] = (PROD_WIDTH+1)'(r2_p[0]) - (PROD_WIDTH+1)'(r2_p[1]);
        diffp[1] = (PROD_WIDTH+1)'(r2_p[2]) - (PROD_WIDTH+1)'(r2_p[3]);
        diffp[2] = (PROD_WIDTH+1)'(r2_p[4]) - (PROD_WIDTH+1)'(r2_p[5]);
        len2_sum = LEN2_WIDTH'(r5_sq[0]) + LEN2_WIDTH'(r5_sq[1])
                 + LEN2_WIDTH'(r5_sq[2]);
    end

    always_ff @(posedge i_clk) begin
        if (adv[0]) begin
            r1_u[0] <= DIFF_WIDTH'(i_data.b_x) - DIFF_WIDTH'(i_data.a_x);
            r1_u[1] <= DIFF_WIDTH'(i_data.b_y) - DIFF_WIDTH'(i_data.a_y);
            r1_u[2] <= DIFF_WIDTH'(i_data.b_z) - DIFF_WIDTH'(i_data.a_z);
            r1_w[0] <= DIFF_WIDTH'(i_data.c_x) - DIFF_WIDTH'(i_data.a_x);
            r1_w[1] <= DIFF_WIDTH'(i_data.c_y) - DIFF_WIDTH'(i_data.a_y);
            r1_w[2] <= DIFF_WIDTH'(i_data.c_z) - DIFF_WIDTH'(i_data.a_z);
        end
        if (adv[1]) begin
            r2_p[0] <= PROD_WIDTH'(r1_u[1]) * PROD_WIDTH'(r1_w[2]);
            r2_p[1] <= PROD_WIDTH'(r1_w[1]) * PROD_WIDTH'(r1_u[2]);
            r2_p[2] <= PROD_WIDTH'(r1_u[2]) * PROD_WIDTH'(r1_w[0]);
            r2_p[3] <= PROD_WIDTH'(r1_w[2]) * PROD_WIDTH'(r1_u[0]);
            r2_p[4] <= PROD_WIDTH'(r1_u[0]) * PROD_WIDTH'(r1_w[1]);
            r2_p[5] <= PROD_WIDTH'(r1_w[0]) * PROD_WIDTH'(r1_u[1]);
        end
        if (adv[2]) begin
            for (int i = 0; i < 3; i++) begin
                r3_xp[i] <= diffp[i][CROSS_WIDTH-1:0];
            end
        end
        if (adv[3]) begin
            for (int i = 0; i < 3; i++) begin
                r4_neg[i] <= r3_xp[i][CROSS_WIDTH-1];
                r4_m[i]   <= r3_xp[i][CROSS_WIDTH-1] ? CROSS_WIDTH'(-r3_xp[i])
                                                     : CROSS_WIDTH'(r3_xp[i]);
            end
            r4_zero <= (r3_xp[0] == '0) && (r3_xp[1] == '0) && (r3_xp[2] == '0);
        end
        if (adv[4]) begin
            for (int i = 0; i < 3; i++) begin
                r5_sq[i] <= SQ_WIDTH'(r4_m[i]) * SQ_WIDTH'(r4_m[i]);
            end
            r5_neg  <= r4_neg;
            r5_zero <= r4_zero;
        end
        if (adv[5]) begin
            for (int i = 0; i < 3; i++) begin
                r6_work.rem[i]  <= REM_WIDTH'(r5_sq[i]) << (2 * NORMAL_FRAC_BITS);
                r6_work.prod[i] <= '0;
                r6_work.quot[i] <= '0;
            end
            r6_work.len2  <= len2_sum;
            r6_work.neg   <= r5_neg;
            r6_work.degen <= r5_zero;
        end
    end

endmodule

// File: rtl/tfn_div_step.sv
// One stage of the quotient search: decides one bit of each of the three
// normal components with shifts, adds and one wide subtract and compare each. Uses tfn_pkg.
module tfn_div_step
    import tfn_pkg::*;
#(
    parameter int BIT = 0
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  t_norm_work i_data,
    output logic       o_valid,
    input  logic       i_ready,
    output t_norm_work o_data
);

    logic       r_v;
    t_norm_work r_work;
    t_norm_work n_work;
    logic       adv;

    logic [REM_WIDTH-1:0] trial [3];
    logic [REM_WIDTH:0]   diff  [3];

    assign adv     = !r_v || i_ready;
    assign o_ready = adv;
    assign o_valid = r_v;
    assign o_data  = r_work;

    // Setting bit BIT of q raises q^2 * len2 by prod * 2^(BIT+1) + len2 * 2^(2*BIT).
    always_comb begin
        n_work = i_data;
        for (int i = 0; i < 3; i++) begin
            trial[i] = (i_data.prod[i] << (BIT + 1))
                     + (REM_WIDTH'(i_data.len2) << (2 * BIT));
            diff[i]  = {1'b0, i_data.rem[i]} - {1'b0, trial[i]};
            if (!diff[i][REM_WIDTH]) begin
                n_work.rem[i]       = diff[i][REM_WIDTH-1:0];
                n_work.prod[i]      = i_data.prod[i]
                                    + (REM_WIDTH'(i_data.len2) << BIT);
                n_work.quot[i][BIT] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (adv) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_work <= n_work;
        end
    end

endmodule

// File: rtl/triangle_face_normal_top.sv
// Triangle unit face normal, top level: front end, quotient search stages
// and the output register. Uses tfn_pkg, tfn_cross and tfn_div_step.
//
// Usage: one input word carries the three vertices A, B, C in Q8.8. The
// block returns one output word per input: the unit normal of
// (B - A) x (C - A) in Q1.14, each component truncated toward zero, and a
// degenerate flag that is set, with zero components, when the cross product
// is the zero vector.
// Both channels use valid and ready. A new word can be taken every cycle
// unless the pipeline is full and stalled; each word passes 22
// register stages: six front-end stages (edges, products, cross product,
// magnitudes, squares, squared length), fifteen search stages that each
// settle one quotient bit, and the output register. The search stage count
// is the number of fraction bits plus one.
// Each stage holds its own valid bit and moves its word on only when the
// next stage is empty or moving, so when the receiver stalls the pipeline
// fills up behind the output register and o_ready falls only once every
// stage holds a word. No word is lost or repeated.
// Reset (synchronous, active low) clears all valid bits; payload registers
// are not reset.
module triangle_face_normal_top
    import tfn_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_tri_in   i_data,
    output logic      o_valid,
    input  logic      i_ready,
    output t_norm_out o_data
);

    localparam int STEPS = NORMAL_FRAC_BITS + 1;

    t_norm_work s_data  [STEPS+1];
    logic       s_valid [STEPS+1];
    logic       s_ready [STEPS+1];

    logic       r_out_v;
    t_norm_out  r_out;
    t_norm_out  n_out;
    logic       out_adv;

    tfn_cross u_cross (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (s_valid[0]),
        .i_ready (s_ready[0]),
        .o_data  (s_data[0])
    );

    // Stage g settles quotient bit NORMAL_FRAC_BITS - g.
    for (genvar g = 0; g < STEPS; g++) begin : g_step
        tfn_div_step #(
            .BIT (NORMAL_FRAC_BITS - g)
        ) u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (s_valid[g]),
            .o_ready (s_ready[g]),
            .i_data  (s_data[g]),
            .o_valid (s_valid[g+1]),
            .i_ready (s_ready[g+1]),
            .o_data  (s_data[g+1])
        );
    end

    assign out_adv        = !r_out_v || i_ready;
    assign s_ready[STEPS] = out_adv;
    assign o_valid        = r_out_v;
    assign o_data         = r_out;

    always_comb begin
        logic [OUT_WIDTH-1:0] mag_val [3];
        logic [OUT_WIDTH-1:0] res [3];
        for (int i = 0; i < 3; i++) begin
            mag_val[i] = OUT_WIDTH'(s_data[STEPS].quot[i]);
            res[i]     = s_data[STEPS].neg[i] ? -mag_val[i] : mag_val[i];
            if (s_data[STEPS].degen) begin
                res[i] = '0;
            end
        end
        n_out.normal_x   = res[0];
        n_out.normal_y   = res[1];
        n_out.normal_z   = res[2];
        n_out.degenerate = s_data[STEPS].degen;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (out_adv) begin
            r_out_v <= s_valid[STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_adv) begin
            r_out <= n_out;
        end
    end

endmodule
